// ===== src/olst_pkg.sv =====
// Shared codes, field widths and port types of the ordered list store.
package olst_pkg;

   localparam int OPCODE_W = 4;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [POS_W-1:0]    position_type;
   typedef logic [VALUE_W-1:0]  value_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [COUNT_W-1:0]  count_type;

   localparam opcode_type OP_GET        = 4'd0;
   localparam opcode_type OP_SET        = 4'd1;
   localparam opcode_type OP_INSERT     = 4'd2;
   localparam opcode_type OP_REMOVE     = 4'd3;
   localparam opcode_type OP_PUSH_BACK  = 4'd4;
   localparam opcode_type OP_PUSH_FRONT = 4'd5;
   localparam opcode_type OP_POP_BACK   = 4'd6;
   localparam opcode_type OP_POP_FRONT  = 4'd7;
   localparam opcode_type OP_CLEAR      = 4'd8;

   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_EMPTY  = 2'd1;
   localparam status_type ST_BOUNDS = 2'd2;
   localparam status_type ST_FULL   = 2'd3;

endpackage

// ===== src/olst_ram.sv =====
// Element store: one write port and one registered read port.
module olst_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ordered_list_store.sv =====
// Bounded ordered list: element store in a synchronous RAM, count and shift sequencer.
// Set, push back, pop back, clear, unused codes, every error and an insert at the end
// finish at acceptance; get waits for the RAM read; insert at p < c with count c shifts
// entries up first (push front is insert at 0), remove at p shifts entries down (pop front
// is remove at 0). Throughput is one item at a time: shifts move one element per cycle.
// Reset clears the count and the control state; the RAM is not cleared (no clearing pass).
module ordered_list_store #(
   parameter int DEPTH      = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  olst_pkg::opcode_type   req_opcode,
   input  olst_pkg::position_type req_position,
   input  olst_pkg::value_type    req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output olst_pkg::status_type   rsp_status,
   output olst_pkg::value_type    rsp_read_value,
   output olst_pkg::count_type    rsp_count_after
);

   import olst_pkg::*;

   // Address, count and compare widths.
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   // Sequencer states.
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_GET      = 3'd1;
   localparam logic [2:0] S_INS      = 3'd2;
   localparam logic [2:0] S_INS_LAST = 3'd3;
   localparam logic [2:0] S_REM      = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         src_ff, src_in;    // entry whose read is in flight
   logic [AW-1:0]         p_ff, p_in;        // insert target
   logic [AW-1:0]         lim_ff, lim_in;    // last source entry of a remove
   logic [ELEM_WIDTH-1:0] val_ff, val_in;    // element held for the final insert write

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff;
   value_type             rsp_read_value_ff;
   count_type             rsp_count_after_ff;

   // RAM ports.
   logic                  we;
   logic [AW-1:0]         waddr;
   logic [ELEM_WIDTH-1:0] wdata;
   logic                  re;
   logic [AW-1:0]         raddr;
   logic [ELEM_WIDTH-1:0] rdata;

   // Decode helpers.
   logic                  req_take;
   logic [PW-1:0]         pos_ext;
   logic [PW-1:0]         cnt_ext;
   logic [CW-1:0]         cnt_m1;
   logic [AW-1:0]         pos_a;
   logic [AW-1:0]         cnt_a;
   logic [AW-1:0]         cnt_m1_a;
   logic                  is_full;
   logic                  is_empty;
   logic [ELEM_WIDTH-1:0] val_elem;

   // Completion of the current item.
   logic                  done;
   status_type            done_status;
   logic [ELEM_WIDTH-1:0] done_elem;

   olst_ram #(
      .DEPTH (DEPTH),
      .WIDTH (ELEM_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_en   (re),
      .rd_addr (raddr),
      .rd_data (rdata)
   );

   // Take a new item only when idle and the result register is free or draining.
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;

   assign pos_ext  = PW'(req_position);
   assign cnt_ext  = PW'(count_ff);
   assign cnt_m1   = count_ff - CW'(1);
   assign pos_a    = pos_ext[AW-1:0];
   assign cnt_a    = count_ff[AW-1:0];
   assign cnt_m1_a = cnt_m1[AW-1:0];
   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign val_elem = ELEM_WIDTH'(req_value);

   // Shifts run one element per cycle: the read of one entry overlaps the write of the
   // entry two places away, so the RAM never sees a read and write to the same entry.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      src_in      = src_ff;
      p_in        = p_ff;
      lim_in      = lim_ff;
      val_in      = val_ff;
      we          = 1'b0;
      waddr       = src_ff;
      wdata       = rdata;
      re          = 1'b0;
      raddr       = src_ff;
      done        = 1'b0;
      done_status = ST_OK;
      done_elem   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               done = 1'b1;
               unique case (req_opcode)
                  OP_GET: begin
                     if (pos_ext >= cnt_ext) begin
                        done_status = ST_BOUNDS;
                     end else begin
                        // Wait in S_GET for the registered RAM read.
                        re       = 1'b1;
                        raddr    = pos_a;
                        done     = 1'b0;
                        state_in = S_GET;
                     end
                  end
                  OP_SET: begin
                     if (pos_ext >= cnt_ext) begin
                        done_status = ST_BOUNDS;
                     end else begin
                        we    = 1'b1;
                        waddr = pos_a;
                        wdata = val_elem;
                     end
                  end
                  OP_INSERT, OP_PUSH_FRONT: begin
                     // Push front is insert at index zero; the bounds check comes first.
                     if (req_opcode == OP_INSERT && pos_ext > cnt_ext) begin
                        done_status = ST_BOUNDS;
                     end else if (is_full) begin
                        done_status = ST_FULL;
                     end else if ((req_opcode == OP_INSERT && pos_ext == cnt_ext) ||
                                  is_empty) begin
                        // Append: nothing to move.
                        we       = 1'b1;
                        waddr    = cnt_a;
                        wdata    = val_elem;
                        count_in = count_ff + CW'(1);
                     end else begin
                        // Start moving entries up from the top.
                        re       = 1'b1;
                        raddr    = cnt_m1_a;
                        src_in   = cnt_m1_a;
                        p_in     = (req_opcode == OP_INSERT) ? pos_a : '0;
                        val_in   = val_elem;
                        done     = 1'b0;
                        state_in = S_INS;
                     end
                  end
                  OP_REMOVE, OP_POP_FRONT: begin
                     // Pop front is remove at index zero; emptiness is checked first.
                     if (is_empty) begin
                        done_status = ST_EMPTY;
                     end else if (req_opcode == OP_REMOVE && pos_ext >= cnt_ext) begin
                        done_status = ST_BOUNDS;
                     end else if ((req_opcode == OP_REMOVE && pos_a == cnt_m1_a) ||
                                  (req_opcode == OP_POP_FRONT && count_ff == CW'(1))) begin
                        // Last element: drop it.
                        count_in = cnt_m1;
                     end else begin
                        // Start moving entries down from just above the hole.
                        re       = 1'b1;
                        raddr    = ((req_opcode == OP_REMOVE) ? pos_a : '0) + AW'(1);
                        src_in   = ((req_opcode == OP_REMOVE) ? pos_a : '0) + AW'(1);
                        lim_in   = cnt_m1_a;
                        done     = 1'b0;
                        state_in = S_REM;
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (is_full) begin
                        done_status = ST_FULL;
                     end else begin
                        we       = 1'b1;
                        waddr    = cnt_a;
                        wdata    = val_elem;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_POP_BACK: begin
                     if (is_empty) begin
                        done_status = ST_EMPTY;
                     end else begin
                        count_in = cnt_m1;
                     end
                  end
                  OP_CLEAR: begin
                     // Keep the stored bits; only the count goes.
                     count_in = '0;
                  end
                  default: begin
                     // Unused codes: answer ok, change nothing.
                  end
               endcase
            end
         end
         S_GET: begin
            done      = 1'b1;
            done_elem = rdata;
            state_in  = S_IDLE;
         end
         S_INS: begin
            // Move entry src up by one.
            we    = 1'b1;
            waddr = src_ff + AW'(1);
            wdata = rdata;
            if (src_ff == p_ff) begin
               state_in = S_INS_LAST;
            end else begin
               re     = 1'b1;
               raddr  = src_ff - AW'(1);
               src_in = src_ff - AW'(1);
            end
         end
         S_INS_LAST: begin
            // Drop the new element into the opened slot.
            we       = 1'b1;
            waddr    = p_ff;
            wdata    = val_ff;
            count_in = count_ff + CW'(1);
            done     = 1'b1;
            state_in = S_IDLE;
         end
         S_REM: begin
            // Move entry src down by one.
            we    = 1'b1;
            waddr = src_ff - AW'(1);
            wdata = rdata;
            if (src_ff == lim_ff) begin
               count_in = cnt_m1;
               done     = 1'b1;
               state_in = S_IDLE;
            end else begin
               re     = 1'b1;
               raddr  = src_ff + AW'(1);
               src_in = src_ff + AW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Hold the result until taken; a new one only lands in a free register.
      rsp_valid_in = done || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in;
      p_ff   <= p_in;
      lim_ff <= lim_in;
      val_ff <= val_in;
      if (done) begin
         rsp_status_ff      <= done_status;
         rsp_read_value_ff  <= VALUE_W'(done_elem);
         rsp_count_after_ff <= COUNT_W'(count_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_count_after = rsp_count_after_ff;

endmodule

// ===== src/olst_checker.sv =====
// Port-level checks of the ordered list store and their bind to the top level.
module olst_checker #(
   parameter int DEPTH = 64
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input olst_pkg::status_type   rsp_status,
   input olst_pkg::value_type    rsp_read_value,
   input olst_pkg::count_type    rsp_count_after
);

   import olst_pkg::*;

   // Come out of reset idle with no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("block not idle after reset");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) &&
                                    $stable(rsp_read_value) && $stable(rsp_count_after)))
      else $error("stalled result changed");

   // Only a successful get returns data.
   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_read_value == '0))
      else $error("failed item returned data");

   // An empty report leaves the list empty.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_count_after == '0))
      else $error("empty status with nonzero count");

   // Full is only reported while the list holds every entry.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_count_after == COUNT_W'(DEPTH)))
      else $error("full status with spare room");

endmodule

bind ordered_list_store olst_checker #(
   .DEPTH (DEPTH)
) u_olst_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_read_value  (rsp_read_value),
   .rsp_count_after (rsp_count_after)
);

// ===== test/list_result_checker.sv =====
// Predictor and response checker for the ordered list store channels.
module list_result_checker
   import olst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  opcode_type   req_opcode,
   input  position_type req_position,
   input  value_type    req_value,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  status_type   rsp_status,
   input  value_type    rsp_read_value,
   input  count_type    rsp_count_after,
   output int           mismatch_count,
   output int           pending_count,
   output count_type    list_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 64;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      status_type status;
      value_type  read_value;
      count_type  count_after;
   } list_result_t;

   value_type    slots [DEPTH];
   int           held;
   int           results_seen;
   list_result_t pending_results [$];

   function automatic status_type insert_at(int pos, value_type val);
      if (pos > held) return ST_BOUNDS;
      if (held >= DEPTH) return ST_FULL;
      for (int k = held; k > pos; k--) slots[k] = slots[k-1];
      slots[pos] = val;
      held++;
      return ST_OK;
   endfunction

   function automatic status_type remove_at(int pos);
      if (held == 0) return ST_EMPTY;
      if (pos >= held) return ST_BOUNDS;
      for (int k = pos; k + 1 < held; k++) slots[k] = slots[k+1];
      held--;
      return ST_OK;
   endfunction

   // Apply one operation to the shadow list and return the result it must produce.
   function automatic list_result_t apply_list_op(opcode_type op, position_type pos,
                                                  value_type val);
      list_result_t r;
      int p;
      r = '0;
      p = int'(pos);
      case (op)
         OP_GET: begin
            if (p >= held) r.status = ST_BOUNDS;
            else r.read_value = slots[p];
         end
         OP_SET: begin
            if (p >= held) r.status = ST_BOUNDS;
            else slots[p] = val;
         end
         OP_INSERT:     r.status = insert_at(p, val);
         OP_REMOVE:     r.status = remove_at(p);
         OP_PUSH_BACK:  r.status = insert_at(held, val);
         OP_PUSH_FRONT: r.status = insert_at(0, val);
         OP_POP_BACK:   r.status = (held == 0) ? ST_EMPTY : remove_at(held - 1);
         OP_POP_FRONT:  r.status = (held == 0) ? ST_EMPTY : remove_at(0);
         OP_CLEAR:      held = 0;
         default: ;
      endcase
      r.count_after = count_type'(held);
      return r;
   endfunction

   always @(posedge clock) begin : track
      list_result_t want;
      if (reset) begin
         held = 0;
         results_seen = 0;
         mismatch_count = 0;
         pending_results.delete();
      end else begin
         // results first: a result never belongs to an item accepted at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("result %0d arrived with nothing expected: status %0d read %h count %0d",
                           results_seen, rsp_status, rsp_read_value, rsp_count_after);
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status || rsp_read_value !== want.read_value ||
                   rsp_count_after !== want.count_after) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("result %0d: status %0d/%0d read %h/%h count %0d/%0d (exp/got)",
                              results_seen, want.status, rsp_status, want.read_value,
                              rsp_read_value, want.count_after, rsp_count_after);
               end
            end
            results_seen++;
         end
         if (req_valid && !req_stall)
            pending_results.push_back(apply_list_op(req_opcode, req_position, req_value));
      end
      pending_count = pending_results.size();
      list_count = count_type'(held);
   end

endmodule

// ===== test/ordered_list_store_tb.sv =====
// Stimulus and verdict for the ordered list store, with the result checker beside it.
module ordered_list_store_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import olst_pkg::*;

   localparam int ITEM_TOTAL     = 1850;  // items that do real work
   localparam int QUIET_TAIL     = 200;   // last items run with no idling
   localparam int PRESSURE_AFTER = 300;   // when the receiver starts its long hold
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 80;    // time for stray results after the drain

   // Unused opcodes the block must pass through untouched.
   localparam opcode_type OP_UNUSED_LOW  = 4'd9;
   localparam opcode_type OP_UNUSED_HIGH = 4'd15;

   // Position selectors; a non-negative position is used as given.
   localparam int PICK_INSIDE = -1;  // 0 .. count
   localparam int PICK_ANY    = -2;  // whole 7-bit range
   localparam int PICK_TAIL   = -3;  // count - 1
   localparam int PICK_END    = -4;  // count

   typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED, SEG_NOISE} segment_kind_e;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   opcode_type   req_opcode;
   position_type req_position;
   value_type    req_value;
   logic         rsp_valid;
   logic         rsp_stall;
   status_type   rsp_status;
   value_type    rsp_read_value;
   count_type    rsp_count_after;

   int           mismatch_count;
   int           pending_count;
   count_type    list_count;
   int           items_done;
   bit           quiet;

   ordered_list_store u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_count_after (rsp_count_after)
   );

   list_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_count_after (rsp_count_after),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .list_count      (list_count)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Offer one item and hold it until accepted. Resolve the position at the
   // driving edge, when the checker's count already reflects every earlier item.
   task automatic send_item(input opcode_type op, input int pos, input value_type val);
      int gap;
      int p;
      gap = 0;
      if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      case (pos)
         PICK_INSIDE: p = $urandom_range(0, list_count);
         PICK_ANY:    p = $urandom_range(0, 127);
         PICK_TAIL:   p = int'(list_count) - 1;
         PICK_END:    p = int'(list_count);
         default:     p = pos;
      endcase
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_position <= position_type'(p);
      req_value    <= val;
      do @(posedge clock); while (req_stall);
      // ignored opcodes do not count toward the item budget
      if (op <= OP_CLEAR) items_done++;
      if (items_done >= ITEM_TOTAL - QUIET_TAIL) quiet = 1'b1;
   endtask

   // Mostly random words, with the all-zero and all-one patterns mixed in.
   function automatic value_type pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) return '1;
      return $urandom;
   endfunction

   // Bias the operation mix so the list both fills to capacity and drains to empty.
   function automatic opcode_type pick_opcode(segment_kind_e seg);
      int r;
      r = $urandom_range(0, 99);
      case (seg)
         SEG_FILL: begin
            if (r < 30) return OP_PUSH_BACK;
            if (r < 55) return OP_PUSH_FRONT;
            if (r < 85) return OP_INSERT;
            if (r < 90) return OP_GET;
            if (r < 95) return OP_SET;
            return OP_REMOVE;
         end
         SEG_DRAIN: begin
            if (r < 25) return OP_POP_BACK;
            if (r < 50) return OP_POP_FRONT;
            if (r < 85) return OP_REMOVE;
            if (r < 92) return OP_GET;
            return OP_SET;
         end
         SEG_MIXED: return opcode_type'($urandom_range(0, 8));
         default:   return opcode_type'($urandom_range(0, 15));
      endcase
   endfunction

   function automatic int pick_position_mode();
      int r;
      r = $urandom_range(0, 99);
      if (r < 78) return PICK_INSIDE;
      if (r < 86) return PICK_TAIL;
      if (r < 92) return PICK_END;
      return PICK_ANY;
   endfunction

   // Stimulus: directed corner cases, then random segments, then the verdict.
   initial begin
      segment_kind_e seg;
      int            seg_left;
      int            r;
      req_valid    = 1'b0;
      req_opcode   = OP_GET;
      req_position = '0;
      req_value    = '0;
      reset        = 1'b1;
      quiet        = 1'b0;
      items_done   = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // empty list: bounds on reads and writes, empty before any index check
      send_item(OP_GET,        0,   32'h0000_0001);
      send_item(OP_POP_BACK,   0,   32'h0);
      send_item(OP_POP_FRONT,  0,   32'h0);
      send_item(OP_REMOVE,     127, 32'h0);
      send_item(OP_SET,        0,   32'hDEAD_BEEF);
      send_item(OP_INSERT,     1,   32'h1111_1111);
      // build a short list through every write path
      send_item(OP_PUSH_BACK,  0,   32'hFFFF_FFFF);
      send_item(OP_PUSH_FRONT, 0,   32'h0000_0000);
      send_item(OP_INSERT,     1,   32'hA5A5_5A5A);
      send_item(OP_INSERT,     3,   32'h1234_5678);
      send_item(OP_GET,        3,   32'h0);
      send_item(OP_GET,        4,   32'h0);
      send_item(OP_SET,        2,   32'h8000_0001);
      send_item(OP_GET,        2,   32'h0);
      send_item(OP_REMOVE,     1,   32'h0);
      send_item(OP_REMOVE,     3,   32'h0);
      // unused codes leave everything alone
      send_item(OP_UNUSED_LOW,  127, 32'hFFFF_FFFF);
      send_item(OP_UNUSED_HIGH, 64,  32'h5555_AAAA);
      send_item(OP_GET,        64,  32'h0);
      send_item(OP_POP_BACK,   0,   32'h0);
      send_item(OP_POP_FRONT,  0,   32'h0);
      send_item(OP_CLEAR,      0,   32'h0);
      send_item(OP_GET,        0,   32'h0);
      send_item(OP_CLEAR,      0,   32'h0);

      // open with a long fill so the full case shows up early
      seg      = SEG_FILL;
      seg_left = 90;
      while (items_done < ITEM_TOTAL) begin
         if (seg_left == 0) begin
            r = $urandom_range(0, 9);
            if (r < 3) seg = SEG_FILL;
            else if (r < 6) seg = SEG_DRAIN;
            else if (r < 9) seg = SEG_MIXED;
            else seg = SEG_NOISE;
            seg_left = $urandom_range(10, 80);
         end
         send_item(pick_opcode(seg), (seg == SEG_NOISE) ? PICK_ANY : pick_position_mode(),
                   pick_value());
         seg_left--;
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // drain outstanding results, then give stray results time to show up
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Receiver: random stall bursts, calm stretches, and one long hold that
   // backs the block up while the sender keeps offering items.
   initial begin
      int burst;
      bit pressed;
      rsp_stall = 1'b0;
      pressed   = 1'b0;
      forever begin
         @(negedge clock);
         if (quiet) begin
            rsp_stall <= 1'b0;
         end else if (!pressed && items_done >= PRESSURE_AFTER) begin
            pressed = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 15) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(40, 160)) @(negedge clock);
         end else if ($urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 17);
            rsp_stall <= 1'b1;
            repeat (burst) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
